/* rtl/core/vze_pkg.sv */
`default_nettype none

package vze_pkg;

  // Input beat: raw value and encoding mode.
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  mode;
  } in_item_t;

  // Result beat: one encoded byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] byte_index;
    logic       last;
  } out_item_t;

  // Job handed from the front to the back: mapped value and byte count minus one.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes_m1;
  } job_t;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_ZZ32     = 2'd1;
  localparam logic [1:0] MODE_ZZ64     = 2'd2;

  localparam int GROUP_BITS  = 7;
  localparam int MAX_GROUPS  = 10;
  localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

/* rtl/core/vze_front.sv */
`default_nettype none

module vze_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire vze_pkg::in_item_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output vze_pkg::job_t         job_data
);

  logic          valid_r;
  vze_pkg::job_t job_r;
  vze_pkg::job_t job_nxt;
  logic [63:0]   mapped;
  logic [31:0]   low;

  // Zigzag map by mode; the unsigned mode and the unused mode pass the value through.
  always_comb begin
    low = in_data.value[31:0];
    unique case (in_data.mode)
      vze_pkg::MODE_ZZ32: begin
        mapped = {32'd0, {low[30:0], 1'b0} ^ {32{low[31]}}};
      end
      vze_pkg::MODE_ZZ64: begin
        mapped = {in_data.value[62:0], 1'b0} ^ {64{in_data.value[63]}};
      end
      default: begin
        mapped = in_data.value;
      end
    endcase
  end

  // Find the highest nonzero 7-bit group.
  always_comb begin
    job_nxt.data      = mapped;
    job_nxt.nbytes_m1 = '0;
    for (int g = 1; g < vze_pkg::MAX_GROUPS; g++) begin
      if ((mapped >> (vze_pkg::GROUP_BITS * g)) != 64'd0) begin
        job_nxt.nbytes_m1 = 4'(g);
      end
    end
  end

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job_data  = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vze_queue.sv */
`default_nettype none

module vze_queue #(
  parameter int DEPTH = vze_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire vze_pkg::job_t wr_data,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output vze_pkg::job_t      rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  vze_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vze_back.sv */
`default_nettype none

module vze_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire vze_pkg::job_t job_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vze_pkg::out_item_t out_data
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  vze_pkg::out_item_t out_item_r;
  logic [63:0]        shreg_r;
  logic [3:0]         idx_r;
  logic [3:0]         last_idx_r;
  logic               adv;
  logic               first_last;
  logic               cur_last;

  assign adv        = !out_valid_r || out_ready;
  assign job_ready  = (state_r == ST_IDLE) && adv;
  assign first_last = (job_data.nbytes_m1 == 4'd0);
  assign cur_last   = (idx_r == last_idx_r);
  assign out_valid  = out_valid_r;
  assign out_data   = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (adv && job_valid) begin
            // Emit byte 0 straight from the queue head.
            out_valid_r           <= 1'b1;
            out_item_r.out_byte   <= {!first_last, job_data.data[6:0]};
            out_item_r.byte_index <= 4'd0;
            out_item_r.last       <= first_last;
            shreg_r               <= job_data.data >> vze_pkg::GROUP_BITS;
            idx_r                 <= 4'd1;
            last_idx_r            <= job_data.nbytes_m1;
            if (!first_last) begin
              state_r <= ST_EMIT;
            end
          end else if (adv) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (adv) begin
            out_valid_r           <= 1'b1;
            out_item_r.out_byte   <= {!cur_last, shreg_r[6:0]};
            out_item_r.byte_index <= idx_r;
            out_item_r.last       <= cur_last;
            shreg_r               <= shreg_r >> vze_pkg::GROUP_BITS;
            idx_r                 <= idx_r + 4'd1;
            if (cur_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/varint_zigzag_encoder.sv */
`default_nettype none

// Channel   Ports                          Payload          Beat
// input     in_valid, in_ready, in_data    in_item_t        one value + mode
// output    out_valid, out_ready, out_data out_item_t       one encoded byte
//
// A value encodes to N bytes (1 to 10): the back serializer shifts out one 7-bit
// group per cycle from its shift register while out_ready does not stall it.
// The first byte passes the front register, which loads on the accepting edge,
// then the queue, and last the output register that the back serializer loads.
// Reset clears the valid flags, queue pointers and FSM state. Either side may
// stall: the queue lets the front keep taking values while the back waits on
// out_ready, and the output register holds a byte until taken.

module varint_zigzag_encoder #(
  parameter int QUEUE_DEPTH = vze_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vze_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vze_pkg::out_item_t      out_data
);

  logic          fj_valid;
  logic          fj_ready;
  vze_pkg::job_t fj_data;
  logic          qj_valid;
  logic          qj_ready;
  vze_pkg::job_t qj_data;

  // Front: zigzag map and count the bytes.
  vze_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_data  (fj_data)
  );

  // Decouple front from back.
  vze_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fj_valid),
    .wr_ready (fj_ready),
    .wr_data  (fj_data),
    .rd_valid (qj_valid),
    .rd_ready (qj_ready),
    .rd_data  (qj_data)
  );

  // Back: serialize groups into bytes.
  vze_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qj_valid),
    .job_ready (qj_ready),
    .job_data  (qj_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Every byte but the last carries the continuation bit.
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_byte[7] == !out_data.last))
    else $error("continuation bit disagrees with last flag");

  // Bytes of one value stream back to back with consecutive indexes.
  a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last) |=>
      (out_valid && out_data.byte_index == $past(out_data.byte_index) + 4'd1))
    else $error("byte index did not advance");

  // A new value starts at index zero.
  a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.last) |=>
      (!out_valid || out_data.byte_index == 4'd0))
    else $error("new value did not start at byte zero");

  // No encoding runs past ten bytes.
  a_max_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_index == 4'd9) |-> out_data.last)
    else $error("encoding longer than ten bytes");

endmodule

`default_nettype wire
